// ----- rtl/qpd_pkg.sv -----
// Shared types, character constants and hex helpers for the quoted-printable decoder.
package qpd_pkg;

    // Number of result slots that one encoded byte can produce.
    localparam int RunDepth = 3;

    // Characters the decoder reacts to.
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;

    typedef logic [7:0] byte_t;

    // Results caused by one transfer on the input side.
    typedef struct packed {
        logic [1:0]              count;
        byte_t [RunDepth-1:0]    bytes;
        logic                    eom;
        logic                    marker;
    } qpd_run_t;

    // True for 0-9, a-f and A-F.
    function automatic logic is_hex(input byte_t c);
        is_hex = ((c >= CH_0) && (c <= CH_9)) ||
                 ((c >= CH_LA) && (c <= CH_LF_HEX)) ||
                 ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    // Nibble value of a hex digit; letters of either case share the low bits.
    function automatic logic [3:0] hex_nibble(input byte_t c);
        if (c <= CH_9)
        begin
            hex_nibble = c[3:0];
        end
        else
        begin
            hex_nibble = c[3:0] + 4'd9;
        end
    endfunction

endpackage

// ----- rtl/qpd_decode.sv -----
// Escape decoder: pending-escape state and the results of one encoded byte.
module qpd_decode
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  qpd_pkg::byte_t       in_byte,
    input  logic                 last,
    input  logic                 step,
    output qpd_pkg::qpd_run_t    run
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_EQ,
        MODE_EQ_HEX,
        MODE_EQ_CR
    } mode_t;

    mode_t          mode_reg;
    mode_t          mode_next;
    qpd_pkg::byte_t held_reg;
    qpd_pkg::byte_t held_next;

    // Work out the results of the byte and the state it leaves behind.
    always_comb
    begin
        logic [1:0] n;
        logic       plain;
        n         = 2'd0;
        plain     = 1'b0;
        mode_next = mode_reg;
        held_next = held_reg;
        run       = '0;

        case (mode_reg)
            MODE_IDLE:
            begin
                plain = 1'b1;
            end
            MODE_EQ:
            begin
                if (qpd_pkg::is_hex(in_byte))
                begin
                    held_next = in_byte;
                    mode_next = MODE_EQ_HEX;
                end
                else if (in_byte == qpd_pkg::CH_LF)
                begin
                    mode_next = MODE_IDLE;
                end
                else if (in_byte == qpd_pkg::CH_CR)
                begin
                    mode_next = MODE_EQ_CR;
                end
                else
                begin
                    run.bytes[n] = qpd_pkg::CH_EQ;
                    n            = n + 2'd1;
                    mode_next    = MODE_IDLE;
                    plain        = 1'b1;
                end
            end
            MODE_EQ_HEX:
            begin
                mode_next = MODE_IDLE;
                if (qpd_pkg::is_hex(in_byte))
                begin
                    run.bytes[n] = {qpd_pkg::hex_nibble(held_reg),
                                    qpd_pkg::hex_nibble(in_byte)};
                    n            = n + 2'd1;
                end
                else
                begin
                    run.bytes[n] = qpd_pkg::CH_EQ;
                    n            = n + 2'd1;
                    run.bytes[n] = held_reg;
                    n            = n + 2'd1;
                    plain        = 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                if (in_byte != qpd_pkg::CH_LF)
                begin
                    run.bytes[n] = qpd_pkg::CH_EQ;
                    n            = n + 2'd1;
                    run.bytes[n] = qpd_pkg::CH_CR;
                    n            = n + 2'd1;
                    plain        = 1'b1;
                end
            end
        endcase

        // A byte taken with nothing held: '=' opens an escape, all else passes.
        if (plain)
        begin
            if (in_byte == qpd_pkg::CH_EQ)
            begin
                mode_next = MODE_EQ;
            end
            else
            begin
                run.bytes[n] = in_byte;
                n            = n + 2'd1;
            end
        end

        // At message end, flush held bytes literally and return to idle.
        if (last)
        begin
            case (mode_next)
                MODE_EQ:
                begin
                    run.bytes[n] = qpd_pkg::CH_EQ;
                    n            = n + 2'd1;
                end
                MODE_EQ_HEX:
                begin
                    run.bytes[n] = qpd_pkg::CH_EQ;
                    n            = n + 2'd1;
                    run.bytes[n] = held_next;
                    n            = n + 2'd1;
                end
                MODE_EQ_CR:
                begin
                    run.bytes[n] = qpd_pkg::CH_EQ;
                    n            = n + 2'd1;
                    run.bytes[n] = qpd_pkg::CH_CR;
                    n            = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            mode_next = MODE_IDLE;
            held_next = '0;
            run.eom   = 1'b1;
            // An empty end still needs a result to carry the end flag.
            if (n == 2'd0)
            begin
                run.marker   = 1'b1;
                run.bytes[0] = '0;
                n            = 2'd1;
            end
        end

        run.count = n;
    end

    // State advances only when the byte is handed on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            held_reg <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
        end
    end

endmodule

// ----- rtl/qpd_out_buf.sv -----
// Result register: holds the results of one byte and sends them one per transfer.
module qpd_out_buf
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  qpd_pkg::qpd_run_t    run,
    output logic                 free,
    output logic                 out_valid,
    input  logic                 out_stall,
    output qpd_pkg::byte_t       out_byte,
    output logic                 has_byte,
    output logic                 last_of_run,
    output logic                 end_of_message
);

    logic              vld_reg;
    qpd_pkg::qpd_run_t run_reg;
    logic [1:0]        idx_reg;
    logic              take;
    logic              at_end;
    logic              done;

    // Current slot and whether it closes the run.
    assign at_end = (idx_reg == (run_reg.count - 2'd1));
    assign take   = vld_reg && !out_stall;
    assign done   = take && at_end;
    assign free   = !vld_reg || done;

    assign out_valid      = vld_reg;
    assign out_byte       = run_reg.bytes[idx_reg];
    assign has_byte       = !run_reg.marker;
    assign last_of_run    = at_end;
    assign end_of_message = at_end && run_reg.eom;

    // Control: load a new run, step through slots, drop when the last one goes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            vld_reg <= 1'b1;
            idx_reg <= '0;
        end
        else if (done)
        begin
            vld_reg <= 1'b0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            run_reg <= run;
        end
    end

endmodule

// ----- rtl/quoted_printable_decoder_core.sv -----
// Quoted-printable decoder: every encoded byte gives zero to three decoded bytes. An input
// transfer lands in an input register; the escape decoder turns it, together with the held
// '=' and hex digit, into a run of results that is written to the result register, which
// sends them one transfer at a time. A new byte is taken every cycle as long as the output
// is not stalled and each byte gives at most one result; a byte that gives k results holds
// the result register until all k are sent, since the output side moves one byte per
// transfer. A byte that gives no result (a held '=' or a soft line break) still waits until
// the result register is free, then leaves the input register without loading anything. The
// byte flagged last always gives at least one result, ending in end_of_message; with nothing
// to send it is a single end marker with has_byte low.
module quoted_printable_decoder_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  qpd_pkg::byte_t       in_byte,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_stall,
    output qpd_pkg::byte_t       out_byte,
    output logic                 has_byte,
    output logic                 last_of_run,
    output logic                 end_of_message
);

    logic              in_vld_reg;
    qpd_pkg::byte_t    in_byte_reg;
    logic              in_last_reg;
    logic              buf_free;
    logic              consume;
    logic              accept;
    qpd_pkg::qpd_run_t run;

    // Handshake: the registered byte moves on once the result register can take it.
    assign consume  = in_vld_reg && buf_free;
    assign in_stall = in_vld_reg && !buf_free;
    assign accept   = in_valid && !in_stall;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= last;
        end
    end

    qpd_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (in_byte_reg),
        .last    (in_last_reg),
        .step    (consume),
        .run     (run)
    );

    qpd_out_buf u_out_buf
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (consume && (run.count != 2'd0)),
        .run            (run),
        .free           (buf_free),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .has_byte       (has_byte),
        .last_of_run    (last_of_run),
        .end_of_message (end_of_message)
    );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the quoted-printable decoder core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit    = 300000;
    localparam int RandomItems   = 230;
    localparam int HoldOffCycles = 80;
    localparam int TailCycles    = 8;

    // Escape state of the prediction, mirroring what the decoder holds.
    typedef enum logic [1:0]
    {
        ESC_IDLE,
        ESC_EQ,
        ESC_EQ_HEX,
        ESC_EQ_CR
    } esc_state_t;

    // One decoded result as it should appear on the output side.
    typedef struct
    {
        qpd_pkg::byte_t data;
        logic           has_data;
        logic           run_end;
        logic           msg_end;
    } decoded_t;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    qpd_pkg::byte_t in_byte;
    logic           last;
    logic           out_valid;
    logic           out_stall;
    qpd_pkg::byte_t out_byte;
    logic           has_byte;
    logic           last_of_run;
    logic           end_of_message;

    // Decoder state tracked by the prediction.
    esc_state_t     esc_state;
    qpd_pkg::byte_t held_char;

    decoded_t       decoded_q[$];
    decoded_t       run_q[$];
    qpd_pkg::byte_t msg_q[$];

    int  error_count;
    int  items_sent;
    int  cycle_count;
    bit  tx_burst;
    bit  rx_quiet;
    bit  hold_off_req;

    quoted_printable_decoder_core uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .has_byte       (has_byte),
        .last_of_run    (last_of_run),
        .end_of_message (end_of_message)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run guard: a hung handshake ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CycleLimit)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // True for the characters 0-9, a-f and A-F.
    function automatic bit is_digit_char(input qpd_pkg::byte_t c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    // Value of a hex digit character.
    function automatic logic [3:0] digit_value(input qpd_pkg::byte_t c);
        qpd_pkg::byte_t v;
        if (c >= "0" && c <= "9")
        begin
            v = c - "0";
        end
        else if (c >= "A" && c <= "F")
        begin
            v = c - "A" + 8'd10;
        end
        else
        begin
            v = c - "a" + 8'd10;
        end
        return v[3:0];
    endfunction

    // Appends one literal byte to the run being built.
    function automatic void emit_byte(input qpd_pkg::byte_t b);
        decoded_t r;
        r.data     = b;
        r.has_data = 1'b1;
        r.run_end  = 1'b0;
        r.msg_end  = 1'b0;
        run_q.push_back(r);
    endfunction

    // A byte seen with nothing held: either starts an escape or passes through.
    function automatic void take_plain(input qpd_pkg::byte_t x);
        if (x == qpd_pkg::CH_EQ)
        begin
            esc_state = ESC_EQ;
        end
        else
        begin
            emit_byte(x);
        end
    endfunction

    // Works out the results of one accepted byte and queues them.
    function automatic void decode_byte(input qpd_pkg::byte_t x, input logic fin);
        decoded_t r;
        run_q.delete();
        case (esc_state)
            ESC_IDLE:
            begin
                take_plain(x);
            end
            ESC_EQ:
            begin
                if (is_digit_char(x))
                begin
                    held_char = x;
                    esc_state = ESC_EQ_HEX;
                end
                else if (x == qpd_pkg::CH_LF)
                begin
                    esc_state = ESC_IDLE;
                end
                else if (x == qpd_pkg::CH_CR)
                begin
                    esc_state = ESC_EQ_CR;
                end
                else
                begin
                    emit_byte(qpd_pkg::CH_EQ);
                    esc_state = ESC_IDLE;
                    take_plain(x);
                end
            end
            ESC_EQ_HEX:
            begin
                esc_state = ESC_IDLE;
                if (is_digit_char(x))
                begin
                    emit_byte({digit_value(held_char), digit_value(x)});
                end
                else
                begin
                    emit_byte(qpd_pkg::CH_EQ);
                    emit_byte(held_char);
                    take_plain(x);
                end
            end
            default:
            begin
                esc_state = ESC_IDLE;
                if (x != qpd_pkg::CH_LF)
                begin
                    emit_byte(qpd_pkg::CH_EQ);
                    emit_byte(qpd_pkg::CH_CR);
                    take_plain(x);
                end
            end
        endcase

        // At message end, whatever is still held goes out literally.
        if (fin)
        begin
            case (esc_state)
                ESC_EQ:
                begin
                    emit_byte(qpd_pkg::CH_EQ);
                end
                ESC_EQ_HEX:
                begin
                    emit_byte(qpd_pkg::CH_EQ);
                    emit_byte(held_char);
                end
                ESC_EQ_CR:
                begin
                    emit_byte(qpd_pkg::CH_EQ);
                    emit_byte(qpd_pkg::CH_CR);
                end
                default:
                begin
                end
            endcase
            esc_state = ESC_IDLE;
            held_char = '0;
            if (run_q.size() == 0)
            begin
                r.data     = '0;
                r.has_data = 1'b0;
                r.run_end  = 1'b0;
                r.msg_end  = 1'b0;
                run_q.push_back(r);
            end
            run_q[run_q.size()-1].msg_end = 1'b1;
        end

        if (run_q.size() > 0)
        begin
            run_q[run_q.size()-1].run_end = 1'b1;
        end
        foreach (run_q[i])
        begin
            decoded_q.push_back(run_q[i]);
        end
    endfunction

    // Sender idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (tx_burst)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 24);
    endfunction

    // Random hex digit character of either case.
    function automatic qpd_pkg::byte_t random_digit_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
        begin
            return qpd_pkg::byte_t'("0" + r);
        end
        else if (r < 16)
        begin
            return qpd_pkg::byte_t'("a" + (r - 10));
        end
        return qpd_pkg::byte_t'("A" + (r - 16));
    endfunction

    // Offers one byte and holds it until the transfer completes, then predicts it.
    task automatic send_byte(input qpd_pkg::byte_t b, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        last     <= fin;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        decode_byte(b, fin);
        items_sent++;
    endtask

    // Sends a string of characters, optionally flagging the last one as message end.
    task automatic send_text(input string s, input logic fin);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(qpd_pkg::byte_t'(s[i]), fin && (i == s.len() - 1));
        end
    endtask

    // Sends the message held in msg_q, last flag on its final byte.
    task automatic send_message();
        foreach (msg_q[i])
        begin
            send_byte(msg_q[i], i == msg_q.size() - 1);
        end
    endtask

    // Builds a random message: plain bytes, well-formed escapes and breaks, some broken ones.
    task automatic build_message(input int max_tokens);
        int n_tok;
        int kind;
        msg_q.delete();
        n_tok = $urandom_range(1, max_tokens);
        repeat (n_tok)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                msg_q.push_back(qpd_pkg::byte_t'($urandom_range(0, 255)));
            end
            else if (kind < 60)
            begin
                msg_q.push_back(qpd_pkg::CH_EQ);
                msg_q.push_back(random_digit_char());
                msg_q.push_back(random_digit_char());
            end
            else if (kind < 70)
            begin
                msg_q.push_back(qpd_pkg::CH_EQ);
                msg_q.push_back(qpd_pkg::CH_LF);
            end
            else if (kind < 78)
            begin
                msg_q.push_back(qpd_pkg::CH_EQ);
                msg_q.push_back(qpd_pkg::CH_CR);
                msg_q.push_back(qpd_pkg::CH_LF);
            end
            else if (kind < 84)
            begin
                msg_q.push_back(qpd_pkg::CH_EQ);
                msg_q.push_back(qpd_pkg::byte_t'($urandom_range(0, 255)));
            end
            else if (kind < 90)
            begin
                msg_q.push_back(qpd_pkg::CH_EQ);
                msg_q.push_back(random_digit_char());
                msg_q.push_back(qpd_pkg::byte_t'($urandom_range(0, 255)));
            end
            else if (kind < 95)
            begin
                msg_q.push_back(qpd_pkg::CH_EQ);
                msg_q.push_back(qpd_pkg::CH_CR);
                msg_q.push_back(qpd_pkg::byte_t'($urandom_range(0, 255)));
            end
            else
            begin
                // A dangling '=' that the next token or the message end resolves.
                msg_q.push_back(qpd_pkg::CH_EQ);
            end
        end
    endtask

    // Plain bytes at the extremes and control characters with nothing held.
    task automatic test_literals();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(qpd_pkg::CH_LF, 1'b0);
        send_byte(qpd_pkg::CH_CR, 1'b0);
        send_byte("A", 1'b1);
    endtask

    // Hex escapes in both cases and at both ends of the byte range.
    task automatic test_hex_escapes();
        send_text("=3D=a9=Ff=00", 1'b1);
    endtask

    // Soft line breaks give nothing; one ending a message gives only the end marker.
    task automatic test_soft_breaks();
        send_text("x=\012=\015\012", 1'b0);
        send_text("=\012", 1'b1);
    endtask

    // Equals after equals, a broken escape, CR without LF and an equals before a non-hex byte.
    task automatic test_broken_sequences();
        send_text("==41=4G=\015X=\015==Z", 1'b1);
    endtask

    // Held bytes flushed at message end, from every held state.
    task automatic test_end_flush();
        send_text("=", 1'b1);
        send_text("=7", 1'b1);
        send_text("=\015", 1'b1);
    endtask

    // Random messages with no idling on either side.
    task automatic test_back_to_back();
        int stop_at;
        tx_burst = 1'b1;
        rx_quiet = 1'b1;
        stop_at = items_sent + 30;
        while (items_sent < stop_at)
        begin
            build_message(6);
            send_message();
        end
        tx_burst = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // The receiver holds off for a long stretch while bytes keep coming, so the block fills.
    task automatic test_output_backpressure();
        int stop_at;
        tx_burst = 1'b1;
        hold_off_req = 1'b1;
        stop_at = items_sent + 24;
        while (items_sent < stop_at)
        begin
            build_message(8);
            send_message();
        end
        tx_burst = 1'b0;
    endtask

    // Random messages with random idling on both sides, up to the total item count.
    task automatic test_random_messages();
        int stop_at;
        stop_at = RandomItems;
        while (items_sent < stop_at)
        begin
            build_message(8);
            send_message();
        end
    endtask

    // Receiver stall: random short and long hold-offs, plus the requested long one.
    initial
    begin : rx_stall_drive
        int stall_left;
        int r;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left = HoldOffCycles;
            end
            else if (!rx_quiet)
            begin
                r = $urandom_range(0, 99);
                if (r < 25)
                begin
                    stall_left = $urandom_range(1, 3);
                end
                else if (r < 28)
                begin
                    stall_left = $urandom_range(8, 30);
                end
            end
            out_stall <= (stall_left > 0);
        end
    end

    // Result check: each output transfer against the oldest expectation.
    initial
    begin : result_check
        decoded_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected result: out_byte %0h has_byte %0b", out_byte, has_byte);
                    error_count++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %0h, got %0h", want.data, out_byte);
                        error_count++;
                    end
                    if (has_byte !== want.has_data)
                    begin
                        $error("has_byte: expected %0b, got %0b", want.has_data, has_byte);
                        error_count++;
                    end
                    if (last_of_run !== want.run_end)
                    begin
                        $error("last_of_run: expected %0b, got %0b", want.run_end, last_of_run);
                        error_count++;
                    end
                    if (end_of_message !== want.msg_end)
                    begin
                        $error("end_of_message: expected %0b, got %0b",
                               want.msg_end, end_of_message);
                        error_count++;
                    end
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        error_count  = 0;
        items_sent   = 0;
        tx_burst     = 1'b0;
        rx_quiet     = 1'b0;
        hold_off_req = 1'b0;
        esc_state    = ESC_IDLE;
        held_char    = '0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_byte  <= '0;
        last     <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_literals();
        test_hex_escapes();
        test_soft_breaks();
        test_broken_sequences();
        test_end_flush();
        test_back_to_back();
        test_output_backpressure();
        test_random_messages();

        // Drain: wait for every expected result, then wait out TailCycles for anything stray.
        in_valid <= 1'b0;
        while (decoded_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TailCycles) @(posedge clk);

        if (error_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/qpd_pkg.sv
rtl/qpd_decode.sv
rtl/qpd_out_buf.sv
rtl/quoted_printable_decoder_core.sv
tb/tb_top.sv
